FILE: rtl/ritoa_pkg.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: shared package
// Widths, character codes, item and job types, the reciprocal table used by
// the digit divider, and the digit-to-character mapping.
// ----------------------------------------------------------------------------
package ritoa_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_CHARS   = 33;

	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int DIGIT_W     = 6;
	// The remainder before correction stays below twice the radix, so eight bits hold it.
	localparam int REM_W       = 8;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + MAX_CHARS + 2);

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 6'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN     = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2d;

	localparam logic [63:0] POW_W = 64'd1 << VALUE_WIDTH;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [RADIX_W-1:0]            radix;
		logic                          upper_case;
	} num_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic              last_char;
	} chr_item_t;

	typedef struct packed {
		logic                   neg;
		logic [VALUE_WIDTH-1:0] mag;
		logic [RADIX_W-1:0]     radix;
		logic                   upper;
	} job_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} back_state_t;

	// floor(2^VALUE_WIDTH / r). The quotient estimate taken with it is at most
	// one below the true quotient.
	function automatic logic [VALUE_WIDTH-1:0] recip_of(input logic [RADIX_W-1:0] r);
		logic [VALUE_WIDTH-1:0] m;
		case (r)
			6'd2:    m = VALUE_WIDTH'(POW_W / 2);
			6'd3:    m = VALUE_WIDTH'(POW_W / 3);
			6'd4:    m = VALUE_WIDTH'(POW_W / 4);
			6'd5:    m = VALUE_WIDTH'(POW_W / 5);
			6'd6:    m = VALUE_WIDTH'(POW_W / 6);
			6'd7:    m = VALUE_WIDTH'(POW_W / 7);
			6'd8:    m = VALUE_WIDTH'(POW_W / 8);
			6'd9:    m = VALUE_WIDTH'(POW_W / 9);
			6'd10:   m = VALUE_WIDTH'(POW_W / 10);
			6'd11:   m = VALUE_WIDTH'(POW_W / 11);
			6'd12:   m = VALUE_WIDTH'(POW_W / 12);
			6'd13:   m = VALUE_WIDTH'(POW_W / 13);
			6'd14:   m = VALUE_WIDTH'(POW_W / 14);
			6'd15:   m = VALUE_WIDTH'(POW_W / 15);
			6'd16:   m = VALUE_WIDTH'(POW_W / 16);
			6'd17:   m = VALUE_WIDTH'(POW_W / 17);
			6'd18:   m = VALUE_WIDTH'(POW_W / 18);
			6'd19:   m = VALUE_WIDTH'(POW_W / 19);
			6'd20:   m = VALUE_WIDTH'(POW_W / 20);
			6'd21:   m = VALUE_WIDTH'(POW_W / 21);
			6'd22:   m = VALUE_WIDTH'(POW_W / 22);
			6'd23:   m = VALUE_WIDTH'(POW_W / 23);
			6'd24:   m = VALUE_WIDTH'(POW_W / 24);
			6'd25:   m = VALUE_WIDTH'(POW_W / 25);
			6'd26:   m = VALUE_WIDTH'(POW_W / 26);
			6'd27:   m = VALUE_WIDTH'(POW_W / 27);
			6'd28:   m = VALUE_WIDTH'(POW_W / 28);
			6'd29:   m = VALUE_WIDTH'(POW_W / 29);
			6'd30:   m = VALUE_WIDTH'(POW_W / 30);
			6'd31:   m = VALUE_WIDTH'(POW_W / 31);
			6'd32:   m = VALUE_WIDTH'(POW_W / 32);
			6'd33:   m = VALUE_WIDTH'(POW_W / 33);
			6'd34:   m = VALUE_WIDTH'(POW_W / 34);
			6'd35:   m = VALUE_WIDTH'(POW_W / 35);
			6'd36:   m = VALUE_WIDTH'(POW_W / 36);
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] c;
		if (d >= DIGIT_TEN) begin
			c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {1'b0, d - DIGIT_TEN};
		end else begin
			c = CHAR_ZERO + {1'b0, d};
		end
		return c;
	endfunction

endpackage

FILE: rtl/radix_integer_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII conversion unit
// Converts a signed integer to its text in radix 2 to 36, one character per
// output item, most significant character first, last character marked.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------
//  num     | in        | num_valid / num_ready | value, radix, upper_case
//  chr     | out       | chr_valid / chr_ready | out_char, last_char
//
// Each digit passes through the back-end states ST_MUL, for the reciprocal
// multiply of the magnitude, and ST_FIX, for the remainder correction and
// the push onto the digit stack. The text then leaves at one character per
// cycle while the receiver keeps chr_ready high.
// The front end and a two-entry job queue keep taking items while the back
// end converts, so up to three items can wait ahead of the converter.
// Reset clears all control state; no clearing pass follows it.
// The output register holds a character until it is taken and the
// converter stalls on it without losing any state.
//
module radix_integer_to_ascii_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ritoa_pkg::num_item_t num,
	input  logic                 num_valid,
	output logic                 num_ready,
	output ritoa_pkg::chr_item_t chr,
	output logic                 chr_valid,
	input  logic                 chr_ready
);
	import ritoa_pkg::*;

	// Classified job from the front end into the queue.
	job_t front_job;
	logic front_valid;
	logic front_ready;

	// Job from the queue into the converter.
	job_t queue_job;
	logic queue_valid;
	logic queue_ready;

	// The front end takes the sign apart, forms the magnitude and replaces
	// an out-of-range radix by ten.
	ritoa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	// The queue lets the front end keep accepting items while the converter
	// is busy or stalled on its output.
	ritoa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (front_job),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd       (queue_job),
		.rd_valid (queue_valid),
		.rd_ready (queue_ready)
	);

	// The converter works on one job at a time: digits by repeated division,
	// then the sign and the digits in reverse through the output register.
	ritoa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (queue_job),
		.job_valid (queue_valid),
		.job_ready (queue_ready),
		.chr       (chr),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready)
	);

endmodule

FILE: rtl/ritoa_front.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: front end
// Accepts input items and classifies them into jobs: sign, magnitude and a
// radix already mapped into the legal range.
// ----------------------------------------------------------------------------
module ritoa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ritoa_pkg::num_item_t num,
	input  logic                 num_valid,
	output logic                 num_ready,
	output ritoa_pkg::job_t      job,
	output logic                 job_valid,
	input  logic                 job_ready
);
	import ritoa_pkg::*;

	job_t job_s1;
	logic valid_s1;
	job_t cls;

	always_comb begin
		cls.neg   = num.value[VALUE_WIDTH-1];
		// The most negative value negates to itself, which read unsigned is its magnitude.
		cls.mag   = cls.neg ? (~num.value + 1'b1) : num.value;
		cls.upper = num.upper_case;
		if (num.radix inside {[RADIX_MIN:RADIX_MAX]}) begin
			cls.radix = num.radix;
		end else begin
			cls.radix = RADIX_DEFAULT;
		end
	end

	assign num_ready = !valid_s1 || job_ready;
	assign job       = job_s1;
	assign job_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (num_valid && num_ready) begin
			valid_s1 <= 1'b1;
		end else if (job_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (num_valid && num_ready) begin
			job_s1 <= cls;
		end
	end

endmodule

FILE: rtl/ritoa_queue.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: job queue
// Small first-in first-out buffer between the front end and the converter.
// ----------------------------------------------------------------------------
module ritoa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  ritoa_pkg::job_t wr,
	input  logic            wr_valid,
	output logic            wr_ready,
	output ritoa_pkg::job_t rd,
	output logic            rd_valid,
	input  logic            rd_ready
);
	import ritoa_pkg::*;

	job_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = cnt_q != (QPTR_W + 1)'(QUEUE_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd       = slot_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wr;
		end
	end

endmodule

FILE: rtl/ritoa_back.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: converter back end
// Divides the magnitude by the radix one digit at a time with a reciprocal
// multiply and a single correction, stacks the digit characters, then sends
// the sign and the digits most significant first through an output register.
// ----------------------------------------------------------------------------
module ritoa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ritoa_pkg::job_t      job,
	input  logic                 job_valid,
	output logic                 job_ready,
	output ritoa_pkg::chr_item_t chr,
	output logic                 chr_valid,
	input  logic                 chr_ready
);
	import ritoa_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic [VALUE_WIDTH-1:0]   mag_q;
	logic [RADIX_W-1:0]       radix_q;
	logic                     upper_q;
	logic                     neg_q;
	logic [2*VALUE_WIDTH-1:0] prod_s1;
	logic [CHAR_W-1:0]        stack_q [VALUE_WIDTH];
	logic [CNT_W-1:0]         ndig_q;
	logic [CNT_W-1:0]         emit_q;
	logic [CNT_W-1:0]         sent_q;
	logic                     sign_pend_q;
	chr_item_t                out_q;
	logic                     out_valid_q;

	logic [VALUE_WIDTH-1:0]     q_est;
	logic [REM_W+RADIX_W-1:0]   prod_lo;
	logic [REM_W-1:0]           rem_raw;
	logic [REM_W-1:0]           radix_ext;
	logic                       rem_ge;
	logic [DIGIT_W-1:0]         digit;
	logic [VALUE_WIDTH-1:0]     q_fix;
	logic [CNT_W-1:0]           ndig_inc;
	logic [CNT_W-1:0]           total;
	logic [CNT_W-1:0]           emit_calc;

	logic take_job;
	logic do_push;
	logic out_load;
	logic do_pop;
	logic last_out;

	// Remainder correction: the estimate is the true quotient or one below it,
	// and only the low bits of the remainder matter.
	always_comb begin
		q_est     = prod_s1[2*VALUE_WIDTH-1:VALUE_WIDTH];
		prod_lo   = q_est[REM_W-1:0] * radix_q;
		rem_raw   = mag_q[REM_W-1:0] - prod_lo[REM_W-1:0];
		radix_ext = {{(REM_W-RADIX_W){1'b0}}, radix_q};
		rem_ge    = rem_raw >= radix_ext;
		digit     = DIGIT_W'(rem_ge ? rem_raw - radix_ext : rem_raw);
		q_fix     = q_est + VALUE_WIDTH'(rem_ge);
		ndig_inc  = ndig_q + CNT_W'(1);
		total     = ndig_inc + CNT_W'(neg_q);
		emit_calc = (total > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : total;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_FIX;
			end
			ST_FIX: begin
				state_d = (q_fix == '0) ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (out_load && last_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		job_ready = 1'b0;
		do_push   = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: job_ready = 1'b1;
			ST_FIX:  do_push   = 1'b1;
			ST_EMIT: out_load  = !out_valid_q || chr_ready;
			default: job_ready = 1'b0;
		endcase
		take_job = job_ready && job_valid;
		do_pop   = out_load && !sign_pend_q;
		last_out = (sent_q + CNT_W'(1)) == emit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ndig_q      <= '0;
			emit_q      <= '0;
			sent_q      <= '0;
			sign_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take_job) begin
				ndig_q      <= '0;
				sent_q      <= '0;
				sign_pend_q <= job.neg;
			end
			if (do_push) begin
				ndig_q <= ndig_inc;
				emit_q <= emit_calc;
			end
			if (out_load) begin
				sent_q      <= sent_q + CNT_W'(1);
				sign_pend_q <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (chr_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_job) begin
			mag_q   <= job.mag;
			radix_q <= job.radix;
			upper_q <= job.upper;
			neg_q   <= job.neg;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= mag_q * recip_of(radix_q);
		end
		if (do_push) begin
			mag_q <= q_fix;
		end
		if (out_load) begin
			out_q.out_char  <= sign_pend_q ? CHAR_MINUS : stack_q[0];
			out_q.last_char <= last_out;
		end
	end

	// Digit stack: digits arrive least significant first and leave from the top.
	always_ff @(posedge clk) begin
		if (do_push) begin
			stack_q[0] <= digit_char(digit, upper_q);
			for (int i = 1; i < VALUE_WIDTH; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (do_pop) begin
			for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	assign chr       = out_q;
	assign chr_valid = out_valid_q;

	a_digit_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIX |-> {1'b0, digit} < {1'b0, radix_q})
		else $error("corrected digit is not below the radix");

	a_digit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= CNT_W'(VALUE_WIDTH))
		else $error("digit count exceeds the stack depth");

	a_no_extra_chars: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> sent_q < emit_q)
		else $error("more characters sent than the text holds");

	a_radix_legal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> radix_q >= RADIX_MIN && radix_q <= RADIX_MAX)
		else $error("converter running with an illegal radix");

endmodule

FILE: tb/sv/ritoa_text_monitor.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: text monitor
// Watches both channels of the conversion unit. It spells every accepted
// number into the characters that should follow, and compares each character
// taken from the unit against the oldest one still owed.
// ----------------------------------------------------------------------------
module ritoa_text_monitor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ritoa_pkg::num_item_t num,
	input  logic                 num_valid,
	input  logic                 num_ready,
	input  ritoa_pkg::chr_item_t chr,
	input  logic                 chr_valid,
	input  logic                 chr_ready,
	output int                   failures,
	output int                   owed,
	output int                   chars_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import ritoa_pkg::*;

	chr_item_t text_due[$];

	// Appends the text of one number, most significant character first.
	function automatic void spell_number(input num_item_t n);
		logic [VALUE_WIDTH:0]   mag;
		logic [VALUE_WIDTH:0]   d;
		logic [RADIX_W-1:0]     base;
		logic [CHAR_W-1:0]      rev[0:VALUE_WIDTH+1];
		logic                   neg;
		int                     len;
		int                     count;
		chr_item_t              c;
		len = 0;
		neg = n.value[VALUE_WIDTH-1];
		// One spare bit keeps the magnitude of the most negative value exact.
		mag = neg ? ({1'b0, ~n.value} + (VALUE_WIDTH+1)'(1)) : {1'b0, n.value};
		base = (n.radix < RADIX_MIN || n.radix > RADIX_MAX) ? RADIX_DEFAULT : n.radix;
		if (mag == 0) begin
			rev[len] = CHAR_ZERO;
			len = len + 1;
		end
		while (mag != 0) begin
			d = mag % base;
			if (d >= DIGIT_TEN) begin
				rev[len] = (n.upper_case ? CHAR_UPPER_A : CHAR_LOWER_A)
					+ CHAR_W'(d - DIGIT_TEN);
			end else begin
				rev[len] = CHAR_ZERO + CHAR_W'(d);
			end
			mag = mag / base;
			len = len + 1;
		end
		if (neg) begin
			rev[len] = CHAR_MINUS;
			len = len + 1;
		end
		count = (len < MAX_CHARS) ? len : MAX_CHARS;
		for (int k = 0; k < count; k++) begin
			c.out_char  = rev[len-1-k];
			c.last_char = (k == count - 1);
			text_due.push_back(c);
		end
	endfunction

	initial begin
		failures   = 0;
		chars_seen = 0;
		owed       = 0;
	end

	always @(posedge clk) begin
		chr_item_t want;
		if (arst_n) begin
			if (chr_valid && chr_ready) begin
				chars_seen <= chars_seen + 1;
				if (text_due.size() == 0) begin
					$display("%0t: unexpected character: expected none, actual %h last %b",
						$time, chr.out_char, chr.last_char);
					failures = failures + 1;
				end else begin
					want = text_due.pop_front();
					if (chr.out_char !== want.out_char) begin
						$display("%0t: out_char mismatch: expected %h, actual %h",
							$time, want.out_char, chr.out_char);
						failures = failures + 1;
					end
					if (chr.last_char !== want.last_char) begin
						$display("%0t: last_char mismatch: expected %b, actual %b",
							$time, want.last_char, chr.last_char);
						failures = failures + 1;
					end
				end
			end
			// Spelled after the pop, so a character taken here is checked only against text owed from earlier numbers.
			if (num_valid && num_ready) begin
				spell_number(num);
			end
			owed = text_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_radix_integer_to_ascii_unit.sv
// ----------------------------------------------------------------------------
// Radix integer to ASCII: testbench top
// Drives numbers into the conversion unit in random bursts, takes the text
// out under changing back-pressure, and gives the verdict from the counts of
// failures and of owed characters that the text monitor reports.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_ascii_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import ritoa_pkg::*;

	// Cycles with no item moving on either channel before the run is declared
	// hung. The longest honest quiet spell is the deliberate output hold-off
	// plus one radix-2 conversion.
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int QUIET_LIMIT     = 4000;
	localparam int RANDOM_ITEMS    = 408;
	localparam int DRAIN_CYCLES    = 150;

	logic      clk;
	logic      arst_n;
	num_item_t num;
	logic      num_valid;
	logic      num_ready;
	chr_item_t chr;
	logic      chr_valid;
	logic      chr_ready;

	int failures;
	int owed;
	int chars_seen;
	int items_sent;
	int negatives;
	int odd_radix;
	int quiet;

	num_item_t numbers[$];

	radix_integer_to_ascii_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.chr       (chr),
		.chr_valid (chr_valid),
		.chr_ready (chr_ready)
	);

	ritoa_text_monitor text_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.num        (num),
		.num_valid  (num_valid),
		.num_ready  (num_ready),
		.chr        (chr),
		.chr_valid  (chr_valid),
		.chr_ready  (chr_ready),
		.failures   (failures),
		.owed       (owed),
		.chars_seen (chars_seen)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic num_item_t make_number(input logic [VALUE_WIDTH-1:0] v,
			input logic [RADIX_W-1:0] r, input logic up);
		num_item_t n;
		n.value      = v;
		n.radix      = r;
		n.upper_case = up;
		return n;
	endfunction

	// Values lean toward the interesting corners: tiny magnitudes of either
	// sign, the two ends of the range, and numbers of random bit length so
	// that every text length shows up in every radix.
	function automatic logic [VALUE_WIDTH-1:0] pick_value();
		logic [VALUE_WIDTH-1:0] v;
		case ($urandom_range(0, 7))
			0: v = $urandom_range(0, 40);
			1: v = -$urandom_range(1, 40);
			2: begin
				case ($urandom_range(0, 4))
					0: v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
					1: v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
					2: v = '1;
					3: v = {1'b1, {(VALUE_WIDTH-2){1'b0}}, 1'b1};
					default: v = '0;
				endcase
			end
			3: v = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
			4: v = -($urandom >> $urandom_range(0, VALUE_WIDTH - 1));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly legal radices; the rest fall back to ten inside the unit.
	function automatic logic [RADIX_W-1:0] pick_radix();
		logic [RADIX_W-1:0] r;
		case ($urandom_range(0, 9))
			0: r = RADIX_W'($urandom_range(0, 1));
			1: r = RADIX_W'($urandom_range(37, 63));
			default: r = RADIX_W'($urandom_range(2, 36));
		endcase
		return r;
	endfunction

	// Holds one item on the input until the unit takes it. Returns at the
	// edge of acceptance, so the caller may put the next item up in the
	// same step without valid ever dropping.
	task automatic offer(input num_item_t n);
		num       <= n;
		num_valid <= 1'b1;
		@(posedge clk);
		while (!num_ready) @(posedge clk);
		items_sent = items_sent + 1;
		if (n.value[VALUE_WIDTH-1]) negatives = negatives + 1;
		if (n.radix < RADIX_MIN || n.radix > RADIX_MAX) odd_radix = odd_radix + 1;
	endtask

	// Receiver: runs through stretches of different stall patterns. The
	// third stretch is one long hold-off so that the job queue and front end
	// fill and the unit has to stall its input while numbers keep coming.
	initial begin
		int mode;
		int span;
		int segment;
		chr_ready <= 1'b0;
		segment = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (segment == 2) begin
				chr_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(20, 200);
				for (int i = 0; i < span; i++) begin
					case (mode)
						0: chr_ready <= 1'b1;
						1: chr_ready <= 1'($urandom_range(0, 1));
						2: chr_ready <= ($urandom_range(0, 7) != 0);
						default: chr_ready <= ($urandom_range(0, 4) == 0);
					endcase
					@(posedge clk);
				end
			end
			segment = segment + 1;
		end
	end

	// Watchdog: ends the run if nothing moves for too long.
	initial begin
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((num_valid && num_ready) || (chr_valid && chr_ready)) begin
				quiet = 0;
			end else begin
				quiet = quiet + 1;
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Sender and verdict.
	initial begin
		int burst;
		int gap;
		num_item_t n;
		items_sent = 0;
		negatives  = 0;
		odd_radix  = 0;
		arst_n    <= 1'b0;
		num_valid <= 1'b0;
		num       <= '0;

		// Directed numbers: zero, both ends of the range in the radices that
		// make the longest and shortest text, the most negative value, letter
		// digits in both cases, and radices that must fall back to ten.
		numbers.push_back(make_number(32'd0, 6'd10, 1'b0));
		numbers.push_back(make_number(32'd0, 6'd2, 1'b1));
		numbers.push_back(make_number(32'h7fffffff, 6'd2, 1'b0));
		numbers.push_back(make_number(32'h80000000, 6'd2, 1'b1));
		numbers.push_back(make_number(32'h80000000, 6'd10, 1'b0));
		numbers.push_back(make_number(32'h80000000, 6'd36, 1'b1));
		numbers.push_back(make_number(32'h80000000, 6'd16, 1'b0));
		numbers.push_back(make_number(32'h7fffffff, 6'd36, 1'b0));
		numbers.push_back(make_number(32'hffffffff, 6'd16, 1'b1));
		numbers.push_back(make_number(32'd1, 6'd2, 1'b0));
		numbers.push_back(make_number(32'd35, 6'd36, 1'b1));
		numbers.push_back(make_number(32'd35, 6'd36, 1'b0));
		numbers.push_back(make_number(32'h89abcdef, 6'd16, 1'b1));
		numbers.push_back(make_number(32'h01234567, 6'd16, 1'b0));
		numbers.push_back(make_number(32'd123456789, 6'd0, 1'b1));
		numbers.push_back(make_number(32'd123456789, 6'd1, 1'b0));
		numbers.push_back(make_number(-32'sd987654, 6'd37, 1'b1));
		numbers.push_back(make_number(32'd987654, 6'd63, 1'b0));
		numbers.push_back(make_number(32'd728, 6'd3, 1'b0));
		numbers.push_back(make_number(-32'sd12345, 6'd8, 1'b1));
		numbers.push_back(make_number(32'd1295, 6'd36, 1'b1));
		numbers.push_back(make_number(-32'sd10, 6'd11, 1'b0));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			numbers.push_back(make_number(pick_value(), pick_radix(),
				1'($urandom_range(0, 1))));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bursts of back-to-back numbers with random gaps between them; some
		// bursts are long so that stretches without any input idling occur.
		// During gaps the payload carries junk that must be ignored.
		burst = 0;
		while (numbers.size() != 0) begin
			if (burst == 0) begin
				burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
					: $urandom_range(1, 8);
			end
			n = numbers.pop_front();
			offer(n);
			burst = burst - 1;
			if (numbers.size() == 0) begin
				num_valid <= 1'b0;
			end else if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 5);
				num_valid <= 1'b0;
				num       <= make_number($urandom, RADIX_W'($urandom), 1'($urandom));
				repeat (gap) @(posedge clk);
			end
		end

		// Let every owed character come out, then give the unit time to show
		// any stray extra characters.
		while (owed != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d numbers (%0d negative, %0d with a radix outside 2..36)",
			items_sent, negatives, odd_radix);
		$display("into %0d characters, with one output hold-off of %0d cycles.",
			chars_seen, HOLD_OFF_CYCLES);
		if (failures == 0 && owed == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
